// ----- rtl/core/tds_pkg.sv -----
// Package for the tridiagonal system solver: payload types, queue entry,
// sequencer states and Q16.16 helper functions. No dependencies.
`default_nettype none
package tds_pkg;

  localparam int MAX_N_DEF = 64;
  localparam int ROW_W     = 6;
  localparam int DIV_STEPS = 48;

  typedef struct packed {
    logic signed [31:0] lower_coef;
    logic signed [31:0] diag_coef;
    logic signed [31:0] upper_coef;
    logic signed [31:0] rhs_value;
    logic               last_row;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] solution;
    logic [5:0]         row_index;
    logic               pivot_error;
    logic               is_last;
  } out_item_t;

  // Classified row as it leaves the front part
  typedef struct packed {
    in_item_t         row;
    logic [ROW_W-1:0] idx;
    logic             last;
  } row_item_t;

  typedef struct packed {
    logic      valid;
    row_item_t item;
  } fq_status_t;

  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic signed [31:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_FDIV, S_FMU, S_FSU, S_FSR, S_WRITE,
    S_BRD, S_BMUL, S_BNUM, S_BSTART, S_BDIV, S_BOUT
  } back_state_t;

  // Saturate a 48-bit signed value to 32 bits
  function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
    logic signed [31:0] res;
    if (v > 48'sh0000_7FFF_FFFF) res = 32'sh7FFF_FFFF;
    else if (v < -48'sh0000_8000_0000) res = -32'sh8000_0000;
    else res = v[31:0];
    return res;
  endfunction

  // Finish a Q16.16 product: divide by 65536 toward zero, then saturate
  function automatic logic signed [31:0] qmul_fin(input logic signed [63:0] p);
    logic signed [63:0] adj;
    logic signed [63:0] sh;
    adj = p + (p[63] ? 64'sd65535 : 64'sd0);
    sh  = adj >>> 16;
    return sat48(sh[47:0]);
  endfunction

  // Saturating difference a - b
  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] d;
    logic signed [47:0] e;
    d = 33'(a) - 33'(b);
    e = 48'(d);
    return sat48(e);
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/tds_front.sv -----
// Front part: accepts rows, assigns row index and last mark, queues them.
// Depends on tds_pkg.
`default_nettype none
module tds_front #(
  parameter int MAX_N = tds_pkg::MAX_N_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tds_pkg::in_item_t in_data,
  input  wire logic              push,
  output logic                   full,
  input  wire logic              fq_pop,
  output tds_pkg::fq_status_t    fq_status
);

  localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;

  logic [IW-1:0]       row_cnt_r, row_cnt_nxt;
  tds_pkg::row_item_t  q_r [2];
  logic                wp_r, rp_r;
  logic [1:0]          cnt_r, cnt_nxt;
  logic                acc, last;

  assign full = (cnt_r == 2'd2);
  assign acc  = push && !full;
  assign last = in_data.last_row || (row_cnt_r == IW'(MAX_N - 1));

  // Advance row index, wrap after the last row of a system
  always_comb begin
    row_cnt_nxt = row_cnt_r;
    if (acc) row_cnt_nxt = last ? '0 : row_cnt_r + 1'b1;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (acc && !(fq_pop && cnt_r != 2'd0)) cnt_nxt = cnt_r + 2'd1;
    else if (!acc && fq_pop && cnt_r != 2'd0) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_cnt_r <= '0;
      wp_r      <= 1'b0;
      rp_r      <= 1'b0;
      cnt_r     <= 2'd0;
    end else begin
      row_cnt_r <= row_cnt_nxt;
      cnt_r     <= cnt_nxt;
      if (acc) wp_r <= !wp_r;
      if (fq_pop && cnt_r != 2'd0) rp_r <= !rp_r;
    end
  end

  // Store the classified row
  always_ff @(posedge clk) begin
    if (acc) begin
      q_r[wp_r].row  <= in_data;
      q_r[wp_r].idx  <= tds_pkg::ROW_W'(row_cnt_r);
      q_r[wp_r].last <= last;
    end
  end

  assign fq_status.valid = (cnt_r != 2'd0);
  assign fq_status.item  = q_r[rp_r];

endmodule
`default_nettype wire

// ----- rtl/core/tds_div.sv -----
// Iterative Q16.16 divider: (a*65536)/b toward zero, saturated, one bit a cycle.
// Depends on tds_pkg.
`default_nettype none
module tds_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tds_pkg::div_req_t req,
  output tds_pkg::div_rsp_t      rsp
);

  localparam int DW = tds_pkg::DIV_STEPS;

  logic          busy_r, done_r, neg_r;
  logic [5:0]    cnt_r;
  logic [DW-1:0] dvd_r, dvd_nxt;
  logic [31:0]   rem_r, dm_r, am, bm;
  logic [32:0]   rem_sh, rem_sub;
  logic          ge;
  logic signed [31:0] quot_r, quot_nxt;

  assign am = req.num[31] ? 32'(-req.num) : 32'(req.num);
  assign bm = req.den[31] ? 32'(-req.den) : 32'(req.den);

  // One restoring step
  assign rem_sh  = {rem_r, dvd_r[DW-1]};
  assign ge      = rem_sh >= {1'b0, dm_r};
  assign rem_sub = rem_sh - {1'b0, dm_r};
  assign dvd_nxt = {dvd_r[DW-2:0], ge};

  // Apply sign and saturate
  always_comb begin
    if (neg_r) begin
      if (dvd_nxt > DW'(64'h8000_0000)) quot_nxt = -32'sh8000_0000;
      else quot_nxt = 32'(-dvd_nxt);
    end else begin
      if (dvd_nxt > DW'(64'h7FFF_FFFF)) quot_nxt = 32'sh7FFF_FFFF;
      else quot_nxt = dvd_nxt[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start && !busy_r) busy_r <= 1'b1;
      else if (busy_r && cnt_r == 6'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start && !busy_r) begin
      neg_r <= req.num[31] ^ req.den[31];
      dvd_r <= {am, 16'h0};
      rem_r <= '0;
      dm_r  <= bm;
      cnt_r <= 6'(DW - 1);
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[31:0] : rem_sh[31:0];
      dvd_r <= dvd_nxt;
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd0) quot_r <= quot_nxt;
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule
`default_nettype wire

// ----- rtl/core/tds_back.sv -----
// Back part: elimination and back substitution sequencer with row memories
// and the result register. Depends on tds_pkg; drives the shared divider.
`default_nettype none
module tds_back #(
  parameter int MAX_N = tds_pkg::MAX_N_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire tds_pkg::fq_status_t fq_status,
  output logic                     fq_pop,
  output tds_pkg::div_req_t        div_req,
  input  wire tds_pkg::div_rsp_t   div_rsp,
  output tds_pkg::out_item_t       out_data,
  output logic                     empty,
  input  wire logic                pop
);

  localparam int IW = (MAX_N > 1) ? $clog2(MAX_N) : 1;

  tds_pkg::back_state_t state_r, state_nxt;
  tds_pkg::in_item_t    row_r;
  logic [IW-1:0]        idx_r, i_r;
  logic                 last_r;
  logic signed [31:0]   pd_r, pu_r, pr_r, m_r, d_r, r_r;
  logic signed [31:0]   rd_d_r, rd_u_r, rd_r_r, num_r, x_r;
  logic signed [63:0]   prod_r;
  logic                 err_r;
  logic signed [31:0]   md_mem [MAX_N];
  logic signed [31:0]   mr_mem [MAX_N];
  logic signed [31:0]   mu_mem [MAX_N];
  logic                 out_valid_r;
  tds_pkg::out_item_t   out_r;
  logic                 out_free, load_out;

  assign out_free = !out_valid_r || pop;
  assign load_out = (state_r == tds_pkg::S_BOUT) && out_free;

  // Next state and handshake with queue and divider
  always_comb begin
    state_nxt     = state_r;
    fq_pop        = 1'b0;
    div_req.start = 1'b0;
    div_req.num   = row_r.lower_coef;
    div_req.den   = pd_r;
    unique case (state_r)
      tds_pkg::S_IDLE: if (fq_status.valid) begin
        fq_pop = 1'b1;
        if (fq_status.item.idx == '0 || pd_r == '0) state_nxt = tds_pkg::S_WRITE;
        else begin
          div_req.start = 1'b1;
          div_req.num   = fq_status.item.row.lower_coef;
          state_nxt     = tds_pkg::S_FDIV;
        end
      end
      tds_pkg::S_FDIV:   if (div_rsp.done) state_nxt = tds_pkg::S_FMU;
      tds_pkg::S_FMU:    state_nxt = tds_pkg::S_FSU;
      tds_pkg::S_FSU:    state_nxt = tds_pkg::S_FSR;
      tds_pkg::S_FSR:    state_nxt = tds_pkg::S_WRITE;
      tds_pkg::S_WRITE:  state_nxt = last_r ? tds_pkg::S_BRD : tds_pkg::S_IDLE;
      tds_pkg::S_BRD:    state_nxt = tds_pkg::S_BMUL;
      tds_pkg::S_BMUL:   state_nxt = tds_pkg::S_BNUM;
      tds_pkg::S_BNUM:   state_nxt = tds_pkg::S_BSTART;
      tds_pkg::S_BSTART: begin
        div_req.num = num_r;
        div_req.den = rd_d_r;
        if (rd_d_r == '0) state_nxt = tds_pkg::S_BOUT;
        else begin
          div_req.start = 1'b1;
          state_nxt     = tds_pkg::S_BDIV;
        end
      end
      tds_pkg::S_BDIV:   if (div_rsp.done) state_nxt = tds_pkg::S_BOUT;
      tds_pkg::S_BOUT:   if (out_free)
                           state_nxt = (i_r == '0) ? tds_pkg::S_IDLE : tds_pkg::S_BRD;
      default:           state_nxt = tds_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tds_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) out_valid_r <= 1'b1;
      else if (pop) out_valid_r <= 1'b0;
    end
  end

  // Datapath: one multiplier, saturating subtract, row registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      tds_pkg::S_IDLE: if (fq_status.valid) begin
        row_r  <= fq_status.item.row;
        idx_r  <= fq_status.item.idx[IW-1:0];
        last_r <= fq_status.item.last;
        d_r    <= fq_status.item.row.diag_coef;
        r_r    <= fq_status.item.row.rhs_value;
      end
      tds_pkg::S_FDIV: m_r <= div_rsp.quot;
      tds_pkg::S_FMU:  prod_r <= pu_r * m_r;
      tds_pkg::S_FSU: begin
        d_r    <= tds_pkg::sat_sub(row_r.diag_coef, tds_pkg::qmul_fin(prod_r));
        prod_r <= pr_r * m_r;
      end
      tds_pkg::S_FSR: r_r <= tds_pkg::sat_sub(row_r.rhs_value, tds_pkg::qmul_fin(prod_r));
      tds_pkg::S_WRITE: begin
        md_mem[idx_r] <= d_r;
        mr_mem[idx_r] <= r_r;
        mu_mem[idx_r] <= last_r ? 32'sd0 : row_r.upper_coef;
        pd_r <= d_r;
        pr_r <= r_r;
        pu_r <= last_r ? 32'sd0 : row_r.upper_coef;
        i_r  <= idx_r;
        x_r  <= 32'sd0;
      end
      tds_pkg::S_BRD: begin
        rd_d_r <= md_mem[i_r];
        rd_r_r <= mr_mem[i_r];
        rd_u_r <= mu_mem[i_r];
      end
      tds_pkg::S_BMUL: prod_r <= rd_u_r * x_r;
      tds_pkg::S_BNUM: num_r <= tds_pkg::sat_sub(rd_r_r, tds_pkg::qmul_fin(prod_r));
      tds_pkg::S_BSTART: if (rd_d_r == '0) begin
        x_r   <= 32'sd0;
        err_r <= 1'b1;
      end else err_r <= 1'b0;
      tds_pkg::S_BDIV: if (div_rsp.done) x_r <= div_rsp.quot;
      tds_pkg::S_BOUT: if (out_free) begin
        out_r.solution    <= x_r;
        out_r.row_index   <= 6'(i_r);
        out_r.pivot_error <= err_r;
        out_r.is_last     <= (i_r == '0);
        i_r               <= i_r - 1'b1;
      end
      default: ;
    endcase
  end

  assign out_data = out_r;
  assign empty    = !out_valid_r;

endmodule
`default_nettype wire

// ----- rtl/core/tridiagonal_system_solver.sv -----
// Top level of the tridiagonal system solver: front queue, back sequencer,
// shared divider. Depends on tds_pkg, tds_front, tds_back and tds_div.
//
// Rows of a tridiagonal system are pushed one per transaction; in elimination
// a row goes through a 48-step bit-serial divide and then the multiply and
// subtract steps, while row 0 and rows after a zero pivot skip both. After the
// last row, each solution entry goes through back substitution (memory read,
// multiply, subtract, 48-step divide) and is emitted from the highest index
// down. A two-entry queue lets rows be pushed while the sequencer works, and a
// result register lets the sequencer run ahead of pop.
// The row memories need no clearing after reset.
`default_nettype none
module tridiagonal_system_solver #(
  parameter int MAX_N = tds_pkg::MAX_N_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tds_pkg::in_item_t  in_data,
  input  wire logic               push,
  output logic                    full,
  output tds_pkg::out_item_t      out_data,
  output logic                    empty,
  input  wire logic               pop
);

  tds_pkg::fq_status_t fq_status;
  logic                fq_pop;
  tds_pkg::div_req_t   div_req;
  tds_pkg::div_rsp_t   div_rsp;

  tds_front #(.MAX_N(MAX_N)) u_front (
    .clk, .rst_n, .in_data, .push, .full, .fq_pop, .fq_status
  );

  tds_div u_div (.clk, .rst_n, .req(div_req), .rsp(div_rsp));

  tds_back #(.MAX_N(MAX_N)) u_back (
    .clk, .rst_n, .fq_status, .fq_pop, .div_req, .div_rsp,
    .out_data, .empty, .pop
  );

  // Never start the divider while it is running
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy) else $error("divider restarted while busy");

  // Pop the queue only when it holds a row
  a_fq_pop: assert property (@(posedge clk) disable iff (!rst_n)
    fq_pop |-> fq_status.valid) else $error("queue popped while empty");

  // Last result is row zero and only row zero
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_data.is_last == (out_data.row_index == 6'd0)))
    else $error("last mark does not match row index");

endmodule
`default_nettype wire
